@@ rtl/core/imu_dead_reckoning_integrator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dead reckoning integrator
// Same-cycle and next-cycle implication checks with async reset disable.
// ----------------------------------------------------------------------------
`ifndef IMU_DEAD_RECKONING_INTEGRATOR_ASSERT_SVH
`define IMU_DEAD_RECKONING_INTEGRATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IDR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the following cycle
`define IDR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/idr_pkg.sv @@
// ----------------------------------------------------------------------------
// idr_pkg
// Types and constants shared by the dead reckoning integrator modules.
// ----------------------------------------------------------------------------
package idr_pkg;

	localparam logic signed [15:0] QUAT_ONE      = 16'sd16384;
	localparam logic [20:0]        GRAVITY_RESET = 21'd642689;
	localparam logic [19:0]        USEC_PER_SEC  = 20'd1000000;
	localparam logic [19:0]        HALF_USEC     = 20'd500000;
	// ceil(2^52 / 10^6): exact quotient of any 32 bit value below 4096 * 10^6
	localparam logic [32:0]        USEC_RECIP    = 33'h1_0C6F_7A0C;
	localparam int                 DIV_STEPS     = 8;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic [31:0]        time_stamp;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] world_accel_x;
		logic signed [31:0] world_accel_y;
		logic signed [31:0] world_accel_z;
		logic signed [47:0] vel_x;
		logic signed [47:0] vel_y;
		logic signed [47:0] vel_z;
		logic signed [63:0] pos_x;
		logic signed [63:0] pos_y;
		logic signed [63:0] pos_z;
	} result_t;

	typedef struct packed {
		logic start_rot;
		logic start_int;
	} lane_ctl_t;

	typedef struct packed {
		logic t_rdy;
		logic done;
	} lane_stat_t;

	typedef struct packed {
		logic signed [31:0] world_accel;
		logic signed [47:0] vel;
		logic signed [63:0] pos;
	} lane_res_t;

endpackage

@@ rtl/core/idr_lane.sv @@
// ----------------------------------------------------------------------------
// idr_lane
// One axis: rotation component, velocity and displacement update, using a
// shared 37x33 multiplier, which also divides by 10^6 twelve bits at a time
// through the reciprocal.
// ----------------------------------------------------------------------------
module idr_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  idr_pkg::lane_ctl_t      ctl,
	input  logic signed [15:0]      uj,
	input  logic signed [15:0]      uk,
	input  logic signed [15:0]      w,
	input  logic signed [31:0]      vi,
	input  logic signed [31:0]      vj,
	input  logic signed [31:0]      vk,
	input  logic [31:0]             dt,
	input  logic [20:0]             grav,
	input  logic signed [36:0]      tj,
	input  logic signed [36:0]      tk,
	output logic signed [36:0]      t,
	output idr_pkg::lane_stat_t     stat,
	output idr_pkg::lane_res_t      res
);

	typedef enum logic [24:0] {
		S_IDLE = 25'h0000001,
		S_C0   = 25'h0000002,
		S_C1   = 25'h0000004,
		S_C2   = 25'h0000008,
		S_T    = 25'h0000010,
		S_TW   = 25'h0000020,
		S_R0   = 25'h0000040,
		S_R1   = 25'h0000080,
		S_R2   = 25'h0000100,
		S_R3   = 25'h0000200,
		S_R4   = 25'h0000400,
		S_A    = 25'h0000800,
		S_M    = 25'h0001000,
		S_P0   = 25'h0002000,
		S_P1   = 25'h0004000,
		S_P2   = 25'h0008000,
		S_DM   = 25'h0010000,
		S_DS   = 25'h0020000,
		S_Q    = 25'h0040000,
		S_SG   = 25'h0080000,
		S_V    = 25'h0100000,
		S_X    = 25'h0200000,
		S_XM   = 25'h0400000,
		S_POS  = 25'h0800000,
		S_DONE = 25'h1000000
	} lane_state_t;

	lane_state_t        state_q;
	logic [2:0]         cnt_q;
	logic               pass_q;
	logic signed [47:0] vel_q;
	logic signed [63:0] pos_q;

	logic signed [15:0] uj_q, uk_q, w_q;
	logic signed [31:0] vi_q, vj_q, vk_q;
	logic [31:0]        dt_q;
	logic [20:0]        grav_q;
	logic signed [55:0] acc_q;
	logic signed [36:0] t_q;
	logic signed [69:0] prod_q;
	logic signed [31:0] r_q;
	logic signed [33:0] a_q;
	logic               sign_q;
	logic [63:0]        m_q;
	logic [95:0]        num_q;
	logic [19:0]        rem_q;
	logic [62:0]        mag_q;
	logic signed [63:0] sv_q;
	logic signed [63:0] dv_q;
	logic signed [63:0] x_q;
	logic signed [47:0] vel_old_q;

	logic signed [36:0] ma;
	logic signed [32:0] mb;
	logic signed [56:0] t_sum, t_shift;
	logic signed [55:0] r_sum, r_shift;
	logic [33:0]        abs_a;
	logic [63:0]        abs_x;
	logic [31:0]        dx;
	logic [11:0]        dq;
	logic [31:0]        dr;
	logic signed [63:0] vsum;
	logic signed [47:0] vn;
	logic signed [64:0] psum;
	logic signed [63:0] pn;

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_C0: begin ma = 37'(vk_q); mb = 33'(uj_q); end
			S_C1: begin ma = 37'(vj_q); mb = 33'(uk_q); end
			S_R0: begin ma = t_q;       mb = 33'(w_q);  end
			S_R1: begin ma = tk;        mb = 33'(uj_q); end
			S_R2: begin ma = tj;        mb = 33'(uk_q); end
			S_P0: begin
				ma = signed'(37'(m_q[31:0]));
				mb = signed'(33'(dt_q));
			end
			S_P1: begin
				ma = signed'(37'(m_q[63:32]));
				mb = signed'(33'(dt_q));
			end
			S_DM: begin
				ma = signed'(37'(idr_pkg::USEC_RECIP));
				mb = signed'(33'(dx));
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	always_comb begin
		t_sum   = $signed({acc_q, 1'b0}) + 57'sd8192;
		t_shift = t_sum >>> 14;
		r_sum   = acc_q + 56'sd8192;
		r_shift = r_sum >>> 14;
		abs_a   = a_q[33] ? 34'(-a_q) : 34'(a_q);
		abs_x   = x_q[63] ? 64'(-x_q) : 64'(x_q);
		// partial remainder with the next 12 bit digit; quotient digit from the reciprocal
		dx      = {rem_q, num_q[95:84]};
		dq      = prod_q[63:52];
		dr      = dx - 32'(dq) * 32'(idr_pkg::USEC_PER_SEC);
		vsum    = 64'(vel_q) + sv_q;
		if (vsum > 64'sh0000_7FFF_FFFF_FFFF)
			vn = 48'sh7FFF_FFFF_FFFF;
		else if (vsum < -64'sh0000_8000_0000_0000)
			vn = -48'sh8000_0000_0000;
		else
			vn = vsum[47:0];
		psum = 65'(pos_q) + 65'(sv_q);
		if (psum[64] != psum[63])
			pn = psum[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		else
			pn = psum[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pass_q  <= 1'b0;
			vel_q   <= '0;
			pos_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE, S_DONE: if (ctl.start_rot) state_q <= S_C0;
				S_C0: state_q <= S_C1;
				S_C1: state_q <= S_C2;
				S_C2: state_q <= S_T;
				S_T:  state_q <= S_TW;
				S_TW: if (ctl.start_int) state_q <= S_R0;
				S_R0: state_q <= S_R1;
				S_R1: state_q <= S_R2;
				S_R2: state_q <= S_R3;
				S_R3: state_q <= S_R4;
				S_R4: state_q <= S_A;
				S_A:  state_q <= S_M;
				S_M: begin
					pass_q  <= 1'b0;
					state_q <= S_P0;
				end
				S_P0: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: begin
					cnt_q   <= '0;
					state_q <= S_DM;
				end
				S_DM: state_q <= S_DS;
				S_DS: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'(idr_pkg::DIV_STEPS - 1))
						state_q <= S_Q;
					else
						state_q <= S_DM;
				end
				S_Q:  state_q <= S_SG;
				S_SG: state_q <= pass_q ? S_POS : S_V;
				S_V: begin
					vel_q   <= vn;
					state_q <= S_X;
				end
				S_X:  state_q <= S_XM;
				S_XM: begin
					pass_q  <= 1'b1;
					state_q <= S_P0;
				end
				S_POS: begin
					pos_q   <= pn;
					state_q <= S_DONE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				if (ctl.start_rot) begin
					uj_q      <= uj;
					uk_q      <= uk;
					w_q       <= w;
					vi_q      <= vi;
					vj_q      <= vj;
					vk_q      <= vk;
					dt_q      <= dt;
					grav_q    <= grav;
					vel_old_q <= vel_q;
				end
			end
			S_C1: acc_q <= prod_q[55:0];
			S_C2: acc_q <= acc_q - prod_q[55:0];
			S_T:  t_q   <= t_shift[36:0];
			S_R0: acc_q <= $signed({{10{vi_q[31]}}, vi_q, 14'b0});
			S_R1, S_R2: acc_q <= acc_q + prod_q[55:0];
			S_R3: acc_q <= acc_q - prod_q[55:0];
			S_R4: begin
				if (r_shift > 56'sd2147483647)
					r_q <= 32'sh7FFF_FFFF;
				else if (r_shift < -56'sd2147483648)
					r_q <= -32'sh8000_0000;
				else
					r_q <= r_shift[31:0];
			end
			S_A: a_q <= $signed({13'b0, grav_q}) - 34'(r_q);
			S_M: begin
				sign_q <= a_q[33];
				m_q    <= 64'(abs_a) << 8;
			end
			S_P1: num_q <= 96'(prod_q[63:0]) + 96'(idr_pkg::HALF_USEC);
			S_P2: begin
				num_q <= num_q + {prod_q[63:0], 32'b0};
				rem_q <= '0;
			end
			S_DS: begin
				// shift in one quotient digit, keep the remainder
				rem_q <= dr[19:0];
				num_q <= {num_q[83:0], dq};
			end
			S_Q:  mag_q <= (|num_q[95:63]) ? '1 : num_q[62:0];
			S_SG: sv_q  <= sign_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
			S_V:  dv_q  <= sv_q;
			S_X:  x_q   <= (64'(vel_q) <<< 1) + dv_q;
			S_XM: begin
				sign_q <= x_q[63];
				m_q    <= abs_x << 7;
			end
			default: ;
		endcase
	end

	assign t               = t_q;
	assign stat.t_rdy      = (state_q == S_TW);
	assign stat.done       = (state_q == S_DONE);
	assign res.world_accel = r_q;
	assign res.vel         = vel_old_q;
	assign res.pos         = pos_q;

endmodule

@@ rtl/core/idr_merge.sv @@
// ----------------------------------------------------------------------------
// idr_merge
// Gathers the three lane results into one result word and holds it until
// the consumer takes it.
// ----------------------------------------------------------------------------
module idr_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  idr_pkg::lane_res_t [2:0]     lane_res,
	output logic                         free,
	output logic                         result_valid,
	input  logic                         result_ready,
	output idr_pkg::result_t             result
);

	idr_pkg::result_t out_q;
	logic             valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.world_accel_x <= lane_res[0].world_accel;
			out_q.world_accel_y <= lane_res[1].world_accel;
			out_q.world_accel_z <= lane_res[2].world_accel;
			out_q.vel_x         <= lane_res[0].vel;
			out_q.vel_y         <= lane_res[1].vel;
			out_q.vel_z         <= lane_res[2].vel;
			out_q.pos_x         <= lane_res[0].pos;
			out_q.pos_y         <= lane_res[1].pos;
			out_q.pos_z         <= lane_res[2].pos;
		end
	end

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = out_q;

endmodule

@@ rtl/core/imu_dead_reckoning_integrator.sv @@
// ----------------------------------------------------------------------------
// imu_dead_reckoning_integrator
// Strapdown double integration of IMU samples into velocity and displacement.
// ----------------------------------------------------------------------------
// One sample at a time: a sample is taken when the block is idle, and the
// next sample is taken in the cycle after the result moves into the output
// register; a result waiting on the output does not hold up the next sample
// unless a second one finishes.
// Each axis lane runs its rotation and integration on one 37x33 multiplier,
// then two divisions by 10^6 (velocity step, then displacement step), each
// eight 12 bit digits through the reciprocal. The three axes run side by side.
// The gravity register may be written at any time the block is idle.
`include "imu_dead_reckoning_integrator_assert.svh"

module imu_dead_reckoning_integrator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  idr_pkg::sample_t  sample,
	output logic              result_valid,
	input  logic              result_ready,
	output idr_pkg::result_t  result,
	input  logic              cfg_we,
	input  logic [20:0]       cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WT   = 3'b010,
		ST_WR   = 3'b100
	} top_state_t;

	top_state_t          state_q;
	logic signed [15:0]  qw_q, qx_q, qy_q, qz_q;
	logic [31:0]         last_q;
	logic [20:0]         grav_q;

	logic                accept, all_t, all_done, any_done, free, load;
	logic [31:0]         dt;
	idr_pkg::lane_ctl_t  ctl;
	idr_pkg::lane_stat_t [2:0] stat;
	idr_pkg::lane_res_t  [2:0] lane_res;
	logic signed [15:0]  u_arr [3];
	logic signed [31:0]  v_arr [3];
	logic signed [36:0]  t_arr [3];

	assign sample_ready  = (state_q == ST_IDLE);
	assign accept        = sample_valid && sample_ready;
	assign dt            = sample.time_stamp - last_q;
	assign all_t         = stat[0].t_rdy & stat[1].t_rdy & stat[2].t_rdy;
	assign all_done      = stat[0].done & stat[1].done & stat[2].done;
	assign any_done      = stat[0].done | stat[1].done | stat[2].done;
	assign load          = (state_q == ST_WR) && all_done && free;
	assign ctl.start_rot = accept;
	assign ctl.start_int = (state_q == ST_WT) && all_t;

	assign u_arr[0] = qx_q;
	assign u_arr[1] = qy_q;
	assign u_arr[2] = qz_q;
	assign v_arr[0] = sample.accel_x;
	assign v_arr[1] = sample.accel_y;
	assign v_arr[2] = sample.accel_z;

	for (genvar i = 0; i < 3; i++) begin : g_lane
		idr_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.uj     (u_arr[(i + 1) % 3]),
			.uk     (u_arr[(i + 2) % 3]),
			.w      (qw_q),
			.vi     (v_arr[i]),
			.vj     (v_arr[(i + 1) % 3]),
			.vk     (v_arr[(i + 2) % 3]),
			.dt     (dt),
			.grav   ((i == 2) ? grav_q : 21'd0),
			.tj     (t_arr[(i + 1) % 3]),
			.tk     (t_arr[(i + 2) % 3]),
			.t      (t_arr[i]),
			.stat   (stat[i]),
			.res    (lane_res[i])
		);
	end

	idr_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.lane_res     (lane_res),
		.free         (free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			qw_q    <= idr_pkg::QUAT_ONE;
			qx_q    <= '0;
			qy_q    <= '0;
			qz_q    <= '0;
			last_q  <= '0;
			grav_q  <= idr_pkg::GRAVITY_RESET;
		end else begin
			if (cfg_we)
				grav_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// lanes latch the old orientation; store the new one
						qw_q    <= sample.quat_w;
						qx_q    <= sample.quat_x;
						qy_q    <= sample.quat_y;
						qz_q    <= sample.quat_z;
						last_q  <= sample.time_stamp;
						state_q <= ST_WT;
					end
				end
				ST_WT: if (all_t) state_q <= ST_WR;
				ST_WR: if (load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`IDR_ASSERT_NEXT(a_accept_wait, clk, arst_n, accept, state_q == ST_WT, "accept did not start rotation")
	`IDR_ASSERT_IMPL(a_wt_no_done, clk, arst_n, state_q == ST_WT, !any_done, "lane done during rotation")
	`IDR_ASSERT_NEXT(a_load_pos, clk, arst_n, load, result_valid && result.pos_z == $past(lane_res[2].pos), "result not loaded")
	`IDR_ASSERT_NEXT(a_stamp, clk, arst_n, accept, last_q == $past(sample.time_stamp), "time stamp not stored")

endmodule
